// ===== rtl/gra_pkg.sv =====
`default_nettype none
package gra_pkg;
	localparam int MAX_FREE_RECTS = 64;
	localparam int MAX_ATLAS_SIDE = 4096;
	localparam int NUM_PAGES = 3;
	localparam int SIDE_W = 13;
	localparam int CNT_W = $clog2(MAX_FREE_RECTS + 1);
	localparam int IDX_W = $clog2(MAX_FREE_RECTS);
	localparam int PAGE_W = 2;
	localparam int ADDR_W = $clog2(NUM_PAGES * MAX_FREE_RECTS);
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 13;
	localparam int AREA_W = 2 * SIDE_W;

	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE = 1'd1;

	localparam logic [1:0] ST_PLACED = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [SIDE_W-1:0] x;
		logic [SIDE_W-1:0] y;
		logic [SIDE_W-1:0] w;
		logic [SIDE_W-1:0] h;
	} rect_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page_format;
		logic [11:0] glyph_w;
		logic [11:0] glyph_h;
		logic signed [11:0] bear_x;
		logic signed [11:0] bear_y;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [11:0] region_x;
		logic [11:0] region_y;
		logic [11:0] region_width;
		logic [11:0] region_height;
		logic [PAGE_W-1:0] page_index;
		logic signed [11:0] out_bear_x;
		logic signed [11:0] out_bear_y;
	} res_t;

	function automatic logic [SIDE_W-1:0] sat_side(input logic [SIDE_W-1:0] v);
		if (v == '0) begin
			return SIDE_W'(1);
		end
		if (32'(v) > MAX_ATLAS_SIDE) begin
			return SIDE_W'(MAX_ATLAS_SIDE);
		end
		return v;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/gra_if.sv =====
`default_nettype none
interface gra_req_if;
	logic valid;
	logic ready;
	gra_pkg::req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface gra_res_if;
	logic valid;
	logic ready;
	gra_pkg::res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/guillotine_rect_allocator_unit.sv =====
// Guillotine glyph atlas allocator.
// Requests arrive on req (valid/ready); one result leaves on res per request.
// A request is taken only while the block is idle and its output register is
// free; the result register holds its value until the receiver takes it, and
// the next request may be accepted in the same cycle that result transfers.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken at any edge.
// Requests are handled one at a time. An empty glyph's result goes from
// acceptance through the done state to the result register. Otherwise it
// passes a create step (that first creates each missing page up to the
// requested one), a scan that reads one entry per cycle from the rectangle
// memory (one read, one write port), the evaluate, move and write-last steps
// that pick and remove the chosen entry, up to two writes of split pieces
// and a done step that posts the result. A failed scan adds up to two growth
// writes, a create step and a second scan. After reset there are no pages,
// the initial page side is 256 and the largest side is 1024. The rectangle
// memory needs no clearing: only entries below a page's count are ever read.
`default_nettype none
module guillotine_rect_allocator_unit (
	input wire logic clk,
	input wire logic arst_n,
	gra_req_if.sink req,
	gra_res_if.source res,
	input wire logic cfg_we,
	input wire logic [gra_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [gra_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int SW = gra_pkg::SIDE_W;
	localparam int CW = gra_pkg::CNT_W;
	localparam int IW = gra_pkg::IDX_W;
	localparam int PW = gra_pkg::PAGE_W;
	localparam int AW = gra_pkg::ADDR_W;
	localparam int NP = gra_pkg::NUM_PAGES;
	localparam int MF = gra_pkg::MAX_FREE_RECTS;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_CREATE = 11'b00000000010,
		S_SCAN   = 11'b00000000100,
		S_EVAL   = 11'b00000001000,
		S_MOVE   = 11'b00000010000,
		S_WLAST  = 11'b00000100000,
		S_PUSH1  = 11'b00001000000,
		S_PUSH2  = 11'b00010000000,
		S_GROW1  = 11'b00100000000,
		S_GROW2  = 11'b01000000000,
		S_DONE   = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [SW-1:0] init_q, maxs_q;
	logic [CW-1:0] cnt_q [NP];
	logic [SW-1:0] pw_q [NP];
	logic [SW-1:0] ph_q [NP];
	logic [1:0] created_q;

	gra_pkg::rect_t mem [NP*MF];
	gra_pkg::rect_t rd_q;
	logic mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	gra_pkg::rect_t mem_wd;

	gra_pkg::req_t r_q;
	logic [PW-1:0] page_q;
	logic [SW-1:0] gw_q, gh_q;
	logic [CW-1:0] idx_q;
	logic rd_vld_q;
	logic [IW-1:0] rd_idx_q;
	logic found_q;
	logic [IW-1:0] best_q;
	logic [SW-1:0] besty_q;
	logic [gra_pkg::AREA_W-1:0] barea_q;
	gra_pkg::rect_t o_q;
	logic retried_q;
	gra_pkg::rect_t p1_q, p2_q;
	logic [1:0] np_q;
	logic [SW-1:0] nw_q, nh_q;
	logic out_v_q;
	gra_pkg::res_t out_q;

	logic [PW-1:0] sel;
	assign sel = (32'(req.data.page_format) >= NP) ? '0 : req.data.page_format;

	assign req.ready = (state_q == S_IDLE) && (!out_v_q || res.ready);
	assign res.valid = out_v_q;
	assign res.data = out_q;

	logic [AW-1:0] page_base;
	assign page_base = AW'(32'(page_q) * MF);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	logic [CW-1:0] cur_cnt;
	assign cur_cnt = cnt_q[page_q];
	logic fits;
	logic [gra_pkg::AREA_W-1:0] area;
	assign fits = (rd_q.w >= gw_q) && (rd_q.h >= gh_q);
	assign area = gra_pkg::AREA_W'(rd_q.w) * gra_pkg::AREA_W'(rd_q.h);

	logic [SW-1:0] rw, rh;
	assign rw = o_q.w - gw_q;
	assign rh = o_q.h - gh_q;

	logic [SW-1:0] ms, gwc, ghc, gnw, gnh;
	assign ms = gra_pkg::sat_side(maxs_q);
	always_comb begin
		gwc = pw_q[page_q];
		ghc = ph_q[page_q];
		gnw = ({1'b0, gwc} << 1) > {1'b0, ms} ? ms : SW'({1'b0, gwc} << 1);
		gnh = ({1'b0, ghc} << 1) > {1'b0, ms} ? ms : SW'({1'b0, ghc} << 1);
		if (gnw < gwc) gnw = gwc;
		if (gnh < ghc) gnh = ghc;
	end
	logic [1:0] gadds;
	assign gadds = 2'(gnw > gwc) + 2'(gnh > ghc);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		mem_ra = page_base + AW'(idx_q[IW-1:0]);
		unique case (state_q)
			S_CREATE: begin
				mem_we = 1'b1;
				mem_wa = AW'(32'(created_q) * MF);
				mem_wd = '{x: '0, y: '0, w: gra_pkg::sat_side(init_q),
					h: gra_pkg::sat_side(init_q)};
			end
			S_MOVE: begin
				mem_ra = page_base + AW'(cur_cnt - CW'(1));
			end
			S_WLAST: begin
				mem_we = 1'b1;
				mem_wa = page_base + AW'(best_q);
				mem_wd = rd_q;
			end
			S_PUSH1, S_GROW1: begin
				mem_we = 1'b1;
				mem_wa = page_base + AW'(cur_cnt[IW-1:0]);
				mem_wd = p1_q;
			end
			S_PUSH2, S_GROW2: begin
				mem_we = 1'b1;
				mem_wa = page_base + AW'(cur_cnt[IW-1:0]);
				mem_wd = p2_q;
			end
			default: begin
			end
		endcase
	end

	task automatic finish(input logic [1:0] st);
		out_q.status <= st;
		out_q.region_x <= (st == gra_pkg::ST_PLACED) ? 12'(o_q.x + SW'(1)) : '0;
		out_q.region_y <= (st == gra_pkg::ST_PLACED) ? 12'(o_q.y + SW'(1)) : '0;
		out_q.region_width <= (st == gra_pkg::ST_PLACED) ? r_q.glyph_w : '0;
		out_q.region_height <= (st == gra_pkg::ST_PLACED) ? r_q.glyph_h : '0;
		out_q.page_index <= page_q;
		out_q.out_bear_x <= r_q.bear_x;
		out_q.out_bear_y <= r_q.bear_y;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			init_q <= SW'(256);
			maxs_q <= SW'(1024);
			created_q <= '0;
			out_v_q <= 1'b0;
			rd_vld_q <= 1'b0;
			page_q <= '0;
			for (int i = 0; i < NP; i++) begin
				cnt_q[i] <= '0;
				pw_q[i] <= '0;
				ph_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					gra_pkg::REG_INITIAL_SIZE: init_q <= cfg_data;
					gra_pkg::REG_MAX_SIZE: maxs_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (out_v_q && res.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						r_q <= req.data;
						page_q <= sel;
						gw_q <= SW'(req.data.glyph_w) + SW'(2);
						gh_q <= SW'(req.data.glyph_h) + SW'(2);
						retried_q <= 1'b0;
						o_q <= '0;
						if (req.data.glyph_w == '0 || req.data.glyph_h == '0) begin
							out_q.status <= gra_pkg::ST_PLACED;
							out_q.region_x <= '0;
							out_q.region_y <= '0;
							out_q.region_width <= '0;
							out_q.region_height <= '0;
							out_q.page_index <= sel;
							out_q.out_bear_x <= req.data.bear_x;
							out_q.out_bear_y <= req.data.bear_y;
							state_q <= S_DONE;
						end else begin
							state_q <= S_CREATE;
						end
					end
				end
				S_CREATE: begin
					if (created_q <= page_q) begin
						pw_q[created_q] <= gra_pkg::sat_side(init_q);
						ph_q[created_q] <= gra_pkg::sat_side(init_q);
						cnt_q[created_q] <= CW'(1);
						created_q <= created_q + 2'd1;
					end else begin
						state_q <= S_SCAN;
						idx_q <= '0;
						rd_vld_q <= 1'b0;
						found_q <= 1'b0;
					end
				end
				S_SCAN: begin
					rd_vld_q <= (idx_q < cur_cnt);
					rd_idx_q <= idx_q[IW-1:0];
					if (idx_q < cur_cnt) begin
						idx_q <= idx_q + CW'(1);
					end
					if (rd_vld_q && fits && (!found_q || rd_q.y < besty_q ||
							(rd_q.y == besty_q && area < barea_q))) begin
						found_q <= 1'b1;
						best_q <= rd_idx_q;
						besty_q <= rd_q.y;
						barea_q <= area;
						o_q <= rd_q;
					end
					if (!rd_vld_q && idx_q >= cur_cnt) begin
						state_q <= S_EVAL;
						idx_q <= CW'(best_q);
					end
				end
				S_EVAL: begin
					if (!found_q) begin
						if (retried_q || gadds == 2'd0) begin
							finish(gra_pkg::ST_NO_SPACE);
							state_q <= S_DONE;
						end else if (32'(cur_cnt) + 32'(gadds) > MF) begin
							finish(gra_pkg::ST_FULL);
							state_q <= S_DONE;
						end else begin
							nw_q <= gnw;
							nh_q <= gnh;
							p1_q <= '{x: gwc, y: '0, w: gnw - gwc, h: gnh};
							p2_q <= '{x: '0, y: ghc, w: gwc, h: gnh - ghc};
							np_q <= {gnh > ghc, gnw > gwc};
							state_q <= (gnw > gwc) ? S_GROW1 : S_GROW2;
						end
					end else begin
						state_q <= S_MOVE;
					end
				end
				S_MOVE: begin
					if (32'(cur_cnt) - 1 + 32'(rw != '0) + 32'(rh != '0) > MF) begin
						finish(gra_pkg::ST_FULL);
						state_q <= S_DONE;
					end else begin
						if (rw != '0 && rh != '0) begin
							if (rw >= rh) begin
								p1_q <= '{x: o_q.x + gw_q, y: o_q.y, w: rw, h: o_q.h};
								p2_q <= '{x: o_q.x, y: o_q.y + gh_q, w: gw_q, h: rh};
							end else begin
								p1_q <= '{x: o_q.x, y: o_q.y + gh_q, w: o_q.w, h: rh};
								p2_q <= '{x: o_q.x + gw_q, y: o_q.y, w: rw, h: gh_q};
							end
							np_q <= 2'd2;
						end else if (rw != '0) begin
							p1_q <= '{x: o_q.x + gw_q, y: o_q.y, w: rw, h: o_q.h};
							np_q <= 2'd1;
						end else if (rh != '0) begin
							p1_q <= '{x: o_q.x, y: o_q.y + gh_q, w: o_q.w, h: rh};
							np_q <= 2'd1;
						end else begin
							np_q <= 2'd0;
						end
						state_q <= S_WLAST;
					end
				end
				S_WLAST: begin
					cnt_q[page_q] <= cur_cnt - CW'(1);
					if (np_q == 2'd0) begin
						finish(gra_pkg::ST_PLACED);
						state_q <= S_DONE;
					end else begin
						state_q <= S_PUSH1;
					end
				end
				S_PUSH1: begin
					cnt_q[page_q] <= cur_cnt + CW'(1);
					if (np_q == 2'd2) begin
						state_q <= S_PUSH2;
					end else begin
						finish(gra_pkg::ST_PLACED);
						state_q <= S_DONE;
					end
				end
				S_PUSH2: begin
					cnt_q[page_q] <= cur_cnt + CW'(1);
					finish(gra_pkg::ST_PLACED);
					state_q <= S_DONE;
				end
				S_GROW1: begin
					cnt_q[page_q] <= cur_cnt + CW'(1);
					if (np_q[1]) begin
						state_q <= S_GROW2;
					end else begin
						pw_q[page_q] <= nw_q;
						ph_q[page_q] <= nh_q;
						retried_q <= 1'b1;
						state_q <= S_CREATE;
					end
				end
				S_GROW2: begin
					cnt_q[page_q] <= cur_cnt + CW'(1);
					pw_q[page_q] <= nw_q;
					ph_q[page_q] <= nh_q;
					retried_q <= 1'b1;
					state_q <= S_CREATE;
				end
				S_DONE: begin
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> state_q == S_IDLE)
		else $error("ready outside idle");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q[page_q]) <= MF)
		else $error("free count overflow");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> out_v_q)
		else $error("result lost");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> (!out_v_q || res.ready))
		else $error("result overwritten");
endmodule
`default_nettype wire
